// ----- rtl/forth_data_stack_unit_defines.svh -----
// Assertion macros for the checker of the data stack unit.
`ifndef FORTH_DATA_STACK_UNIT_DEFINES_SVH
`define FORTH_DATA_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FDSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FDSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fdsu_pkg.sv -----
package fdsu_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_DUP   = 3'd1,
    OP_DROP  = 3'd2,
    OP_SWAP  = 3'd3,
    OP_ADD   = 3'd4,
    OP_PRINT = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Which memory slot is addressed: the one at the top entry's own index
  // (count - 1) or the entry just below the top (count - 2).
  typedef enum logic {
    ADDR_TOP,
    ADDR_BELOW
  } addr_sel_e;

  typedef enum logic [1:0] {
    TOS_KEEP,
    TOS_PUSH,
    TOS_RDATA,
    TOS_SUM
  } tos_sel_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_sel_e;

  typedef struct packed {
    logic      mem_en;
    logic      mem_we;
    addr_sel_e addr_sel;
    tos_sel_e  tos_sel;
    cnt_sel_e  cnt_sel;
    logic      finish;
    status_e   status;
    logic      print;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic one;
    logic full;
  } stat_t;

  // Low eight bits of the entry count, whatever the count width.
  function automatic logic [7:0] depth8(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+7:0] wide;
    wide = {8'd0, cnt};
    return wide[7:0];
  endfunction

endpackage

// ----- rtl/forth_data_stack_unit.sv -----
// Forth data stack of signed 32-bit integers.
//
// Command channel: an item (opcode_i, push_value_i) is taken at a rising edge
// where start is high and busy is low. Opcodes are push, dup, drop, swap, add
// and print; the two unused codes do nothing and report ok.
// Result channel: result_valid_o is high for exactly one cycle and marks
// status_o, printed_valid_o, printed_value_o and depth_o. The receiver cannot
// stall the block, so every result must be captured in its strobe cycle.
//
// Push, dup, every error case, and drop or print of the last entry finish
// straight from the idle state; the result shows in the cycle after the item
// is taken, and a new item may be taken in that same cycle. Drop, swap, add
// and print with two or more entries also pass through the read state,
// because the entry below the top must come out of the single-port stack
// memory with its registered read; busy is high there and the result follows.
//
// The top entry is held in a register, so each operation needs at most one
// memory access but swap, which reads and then writes. Reset empties the
// stack at once (the count is cleared); memory contents are left as they are.
module forth_data_stack_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic [fdsu_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [fdsu_pkg::DATA_W-1:0] push_value_i,
  output logic                               busy,
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic                               printed_valid_o,
  output logic signed [fdsu_pkg::DATA_W-1:0] printed_value_o,
  output logic [7:0]                         depth_o
);

  fdsu_pkg::cmd_t  cmd;
  fdsu_pkg::stat_t stat;

  // The controller sequences each item and raises the strobe on the same edge
  // at which the datapath commits the operation and loads its result registers.
  fdsu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .opcode_i(opcode_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy),
    .done_o  (result_valid_o)
  );

  // The datapath owns the count, the top-of-stack register, the stack memory
  // and the result registers.
  fdsu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .push_value_i   (push_value_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .printed_valid_o(printed_valid_o),
    .printed_value_o(printed_value_o),
    .depth_o        (depth_o)
  );

endmodule

// ----- rtl/fdsu_ram.sv -----
module fdsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fdsu_ctrl.sv -----
module fdsu_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [fdsu_pkg::OP_W-1:0]        opcode_i,
  input  fdsu_pkg::stat_t                  stat_i,
  output fdsu_pkg::cmd_t                   cmd_o,
  output logic                             busy,
  output logic                             done_o
);

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_e;

  state_e                      state_q, state_d;
  logic [fdsu_pkg::OP_W-1:0]   op_q, op_d;
  logic                        done_q, done_d;
  fdsu_pkg::cmd_t              cmd;

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = fdsu_pkg::ADDR_TOP;
    cmd.tos_sel  = fdsu_pkg::TOS_KEEP;
    cmd.cnt_sel  = fdsu_pkg::CNT_KEEP;
    cmd.status   = fdsu_pkg::ST_OK;
    state_d      = state_q;
    op_d         = op_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = opcode_i;
          cmd.finish = 1'b1;
          case (opcode_i)
            fdsu_pkg::OP_PUSH: begin
              if (stat_i.full) begin
                cmd.status = fdsu_pkg::ST_OVER;
              end else begin
                // Spill the old top into memory unless the stack was empty.
                cmd.mem_en  = !stat_i.empty;
                cmd.mem_we  = !stat_i.empty;
                cmd.tos_sel = fdsu_pkg::TOS_PUSH;
                cmd.cnt_sel = fdsu_pkg::CNT_INC;
              end
            end
            fdsu_pkg::OP_DUP: begin
              if (stat_i.empty) begin
                cmd.status = fdsu_pkg::ST_UNDER;
              end else if (stat_i.full) begin
                cmd.status = fdsu_pkg::ST_OVER;
              end else begin
                cmd.mem_en  = 1'b1;
                cmd.mem_we  = 1'b1;
                cmd.cnt_sel = fdsu_pkg::CNT_INC;
              end
            end
            fdsu_pkg::OP_DROP, fdsu_pkg::OP_PRINT: begin
              if (stat_i.empty) begin
                cmd.status = fdsu_pkg::ST_UNDER;
              end else if (stat_i.one) begin
                cmd.print   = (opcode_i == fdsu_pkg::OP_PRINT);
                cmd.cnt_sel = fdsu_pkg::CNT_DEC;
              end else begin
                cmd.finish   = 1'b0;
                cmd.mem_en   = 1'b1;
                cmd.addr_sel = fdsu_pkg::ADDR_BELOW;
                state_d      = S_RD;
              end
            end
            fdsu_pkg::OP_SWAP, fdsu_pkg::OP_ADD: begin
              if (stat_i.empty || stat_i.one) begin
                cmd.status = fdsu_pkg::ST_UNDER;
              end else begin
                cmd.finish   = 1'b0;
                cmd.mem_en   = 1'b1;
                cmd.addr_sel = fdsu_pkg::ADDR_BELOW;
                state_d      = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        cmd.finish = 1'b1;
        state_d    = S_IDLE;
        case (op_q)
          fdsu_pkg::OP_DROP: begin
            cmd.tos_sel = fdsu_pkg::TOS_RDATA;
            cmd.cnt_sel = fdsu_pkg::CNT_DEC;
          end
          fdsu_pkg::OP_SWAP: begin
            cmd.mem_en   = 1'b1;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = fdsu_pkg::ADDR_BELOW;
            cmd.tos_sel  = fdsu_pkg::TOS_RDATA;
          end
          fdsu_pkg::OP_ADD: begin
            cmd.tos_sel = fdsu_pkg::TOS_SUM;
            cmd.cnt_sel = fdsu_pkg::CNT_DEC;
          end
          fdsu_pkg::OP_PRINT: begin
            cmd.print   = 1'b1;
            cmd.tos_sel = fdsu_pkg::TOS_RDATA;
            cmd.cnt_sel = fdsu_pkg::CNT_DEC;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = cmd.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy   = (state_q == S_RD);
  assign done_o = done_q;

endmodule

// ----- rtl/fdsu_dpath.sv -----
module fdsu_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fdsu_pkg::cmd_t                    cmd_i,
  input  logic signed [fdsu_pkg::DATA_W-1:0] push_value_i,
  output fdsu_pkg::stat_t                   stat_o,
  output logic [1:0]                        status_o,
  output logic                              printed_valid_o,
  output logic signed [fdsu_pkg::DATA_W-1:0] printed_value_o,
  output logic [7:0]                        depth_o
);

  logic [fdsu_pkg::CNT_W-1:0]  count_q, count_d;
  logic [fdsu_pkg::DATA_W-1:0] tos_q, tos_d;
  logic [fdsu_pkg::DATA_W-1:0] rdata;
  logic [fdsu_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [fdsu_pkg::ADDR_W-1:0] addr;
  fdsu_pkg::status_e           status_q;
  logic                        pvalid_q;
  logic [fdsu_pkg::DATA_W-1:0] pvalue_q;

  // The top entry lives in tos_q; memory slot k holds stack entry k for
  // every entry below the top.
  assign cnt_m1 = count_q - fdsu_pkg::CNT_W'(1);
  assign cnt_m2 = count_q - fdsu_pkg::CNT_W'(2);
  assign addr   = (cmd_i.addr_sel == fdsu_pkg::ADDR_TOP) ? cnt_m1[fdsu_pkg::ADDR_W-1:0]
                                                         : cnt_m2[fdsu_pkg::ADDR_W-1:0];

  fdsu_ram #(
    .WIDTH(fdsu_pkg::DATA_W),
    .DEPTH(fdsu_pkg::STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (cmd_i.mem_en),
    .we_i   (cmd_i.mem_we),
    .addr_i (addr),
    .wdata_i(tos_q),
    .rdata_o(rdata)
  );

  assign stat_o.empty = (count_q == '0);
  assign stat_o.one   = (count_q == fdsu_pkg::CNT_W'(1));
  assign stat_o.full  = (count_q == fdsu_pkg::CNT_W'(fdsu_pkg::STACK_DEPTH));

  always_comb begin
    case (cmd_i.tos_sel)
      fdsu_pkg::TOS_PUSH:  tos_d = push_value_i;
      fdsu_pkg::TOS_RDATA: tos_d = rdata;
      fdsu_pkg::TOS_SUM:   tos_d = tos_q + rdata;
      default:             tos_d = tos_q;
    endcase
    case (cmd_i.cnt_sel)
      fdsu_pkg::CNT_INC: count_d = count_q + fdsu_pkg::CNT_W'(1);
      fdsu_pkg::CNT_DEC: count_d = cnt_m1;
      default:           count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      pvalid_q <= cmd_i.print;
      pvalue_q <= cmd_i.print ? tos_q : '0;
    end
  end

  assign status_o        = status_q;
  assign printed_valid_o = pvalid_q;
  assign printed_value_o = pvalue_q;
  // The count settles on the same edge that raises the result strobe and
  // cannot move again before that strobe cycle ends.
  assign depth_o         = fdsu_pkg::depth8(count_q);

endmodule

// ----- rtl/fdsu_checker.sv -----
`include "forth_data_stack_unit_defines.svh"

module fdsu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_o,
  input logic [1:0]                         status_o,
  input logic                               printed_valid_o,
  input logic signed [fdsu_pkg::DATA_W-1:0] printed_value_o
);

  // A taken item either reports right away or raises busy for its memory read.
  `FDSU_ASSERT_NEXT(a_accept_progress, start && !busy, result_valid_o || busy, "item lost")
  // The memory wait lasts exactly one cycle and always ends in a result.
  `FDSU_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && result_valid_o, "busy too long")
  // A failed operation never prints.
  `FDSU_ASSERT_NOW(a_err_no_print, result_valid_o && status_o != fdsu_pkg::ST_OK, !printed_valid_o, "print on error")
  // Without a print the value field is zero.
  `FDSU_ASSERT_NOW(a_quiet_zero, result_valid_o && !printed_valid_o, printed_value_o == '0, "value without print")
  // Only the three defined status codes appear.
  `FDSU_ASSERT_NOW(a_status_code, result_valid_o, status_o <= fdsu_pkg::ST_OVER, "bad status")

endmodule

bind forth_data_stack_unit fdsu_checker u_fdsu_checker (.*);
